[rtl/lrupr_pkg.sv]
package lrupr_pkg;

  // Reset value and width of the frame budget register
  localparam int unsigned CFG_W          = 4;
  localparam logic [3:0]  FRAMES_RST     = 4'd4;
  localparam int unsigned FAULT_W        = 32;
  localparam int unsigned OCC_OUT_W      = 4;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic accept;   // a request is taken this cycle
    logic hit;      // the request matches a resident page
    logic evict;    // a miss with occupancy at the frame budget drops the least recent page
  } cell_ctl_t;

  // Status a cell hands to its neighbors
  typedef struct packed {
    logic valid;    // cell holds a resident page
    logic seen;     // a match sits in this cell or further down the row
  } cell_stat_t;

endpackage

[rtl/lrupr_cell.sv]
module lrupr_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrupr_pkg::cell_ctl_t   ctl,
  input  logic [PAGE_BITS-1:0]   req_page,
  input  logic [PAGE_BITS-1:0]   prev_page,
  input  logic                   prev_valid,
  input  logic                   seen_in,
  output logic [PAGE_BITS-1:0]   page_o,
  output lrupr_pkg::cell_stat_t  stat_o
);

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_nxt;
  logic                 valid_r;
  logic                 valid_nxt;
  logic                 match;
  logic                 load;

  // Compare the request against the held page
  assign match = valid_r && (page_r == req_page);

  // Shift in from the upper neighbor: on a hit every cell down to the match,
  // on a miss every resident cell plus the first free one unless a page is evicted
  assign load = ctl.accept &&
                (ctl.hit ? (match || seen_in)
                         : (valid_r || (prev_valid && !ctl.evict)));

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    if (load) begin
      page_nxt  = prev_page;
      valid_nxt = valid_r | prev_valid;
    end
  end

  // Hold the page; the payload needs no reset since valid gates it
  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign page_o       = page_r;
  assign stat_o.valid = valid_r;
  assign stat_o.seen  = match | seen_in;

endmodule

[rtl/lru_page_replacement_unit.sv]
// Channel  Direction  Accept when             Payload
// in_      slave      in_tvalid & in_tready   page_number
// out_     master     out_tvalid & out_tready fault, evicted_valid, evicted_page,
//                                             fault_total, occupancy
// cfg_     slave      cfg_valid & cfg_ready   frames_in_use
//
// One reference per clock: the row of MAX_FRAMES cells compares the page in
// parallel, ripples the match flag up the row and shifts in the same cycle.
// The result register frees a slot every cycle the output side takes a result.
// Reset (rst_n low, synchronous) empties the stack, zeroes the fault count and
// sets frames_in_use to 4. A stalled output holds its result and blocks input.
module lru_page_replacement_unit #(
  parameter int unsigned MAX_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 16,
  localparam int unsigned IN_W      = ((PAGE_BITS + 7) / 8) * 8,
  localparam int unsigned RES_W     = 2 + PAGE_BITS + lrupr_pkg::FAULT_W
                                      + lrupr_pkg::OCC_OUT_W,
  localparam int unsigned OUT_W     = ((RES_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,   // page_number
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // fault, evicted_valid, evicted_page,
                                          // fault_total, occupancy
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned OCC_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W   = (OCC_W > lrupr_pkg::CFG_W) ? OCC_W : lrupr_pkg::CFG_W;
  localparam int unsigned FAULT_W = lrupr_pkg::FAULT_W;

  logic [lrupr_pkg::CFG_W-1:0] frames_r;
  logic [OCC_W-1:0]            used_r;
  logic [OCC_W-1:0]            used_nxt;
  logic [FAULT_W-1:0]          fault_cnt_r;
  logic [FAULT_W-1:0]          fault_cnt_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [RES_W-1:0]            res_r;
  logic [RES_W-1:0]            res_nxt;

  logic                        in_acc;
  logic [PAGE_BITS-1:0]        req_page;
  logic [CMP_W-1:0]            cap;
  logic [CMP_W-1:0]            used_ext;
  logic                        full;
  logic                        hit;
  logic                        evict;
  logic [PAGE_BITS-1:0]        ev_page;
  logic [CMP_W-1:0]            occ_ext;

  lrupr_pkg::cell_ctl_t        ctl;
  logic [PAGE_BITS-1:0]        page_q [MAX_FRAMES];
  lrupr_pkg::cell_stat_t       stat   [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]       valid_vec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign req_page  = in_tdata[PAGE_BITS-1:0];
  assign cfg_ready = 1'b1;

  // Clamp the frame budget to 1..MAX_FRAMES
  always_comb begin
    cap = CMP_W'(frames_r);
    if (frames_r == '0) begin
      cap = CMP_W'(1);
    end else if (CMP_W'(frames_r) > CMP_W'(MAX_FRAMES)) begin
      cap = CMP_W'(MAX_FRAMES);
    end
  end

  assign used_ext = CMP_W'(used_r);
  assign full     = used_ext >= cap;
  assign hit      = stat[0].seen;
  assign evict    = !hit && full;

  assign ctl.accept = in_acc;
  assign ctl.hit    = hit;
  assign ctl.evict  = evict;

  // Build the cell row; data flows down, the match flag ripples up
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] prev_page;
    logic                 prev_valid;
    logic                 seen_in;

    if (i == 0) begin : g_head
      assign prev_page  = req_page;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_page  = page_q[i-1];
      assign prev_valid = stat[i-1].valid;
    end

    if (i == MAX_FRAMES - 1) begin : g_tail
      assign seen_in = 1'b0;
    end else begin : g_link
      assign seen_in = stat[i+1].seen;
    end

    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .req_page   (req_page),
      .prev_page  (prev_page),
      .prev_valid (prev_valid),
      .seen_in    (seen_in),
      .page_o     (page_q[i]),
      .stat_o     (stat[i])
    );

    assign valid_vec[i] = stat[i].valid;
  end

  // Pick the least recent page: the last resident cell
  always_comb begin
    ev_page = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (valid_vec[i] && ((i == MAX_FRAMES - 1) || !valid_vec[(i + 1) % MAX_FRAMES])) begin
        ev_page = ev_page | page_q[i];
      end
    end
    if (!evict) begin
      ev_page = '0;
    end
  end

  // Advance occupancy and the saturating fault count
  always_comb begin
    used_nxt      = used_r;
    fault_cnt_nxt = fault_cnt_r;
    if (in_acc && !hit) begin
      if (!full) begin
        used_nxt = used_r + OCC_W'(1);
      end
      if (fault_cnt_r != {FAULT_W{1'b1}}) begin
        fault_cnt_nxt = fault_cnt_r + FAULT_W'(1);
      end
    end
  end

  assign occ_ext = CMP_W'(used_nxt);

  // Load the result register on a request, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      res_nxt = {occ_ext[lrupr_pkg::OCC_OUT_W-1:0], fault_cnt_nxt, ev_page, evict, !hit};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r    <= lrupr_pkg::FRAMES_RST;
      used_r      <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_r <= cfg_data;
      end
      used_r      <= used_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(res_r);

  // Resident cells form a prefix whose length is the occupancy
  a_occ_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(used_r))
    else $error("cell valid count differs from occupancy");

  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(used_r) <= CMP_W'(MAX_FRAMES))
    else $error("occupancy above frame count");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && hit) |=> (!res_r[1] && (used_r == $past(used_r))))
    else $error("hit changed occupancy or evicted a page");

  a_miss_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !hit && !full) |=> (used_r == $past(used_r) + OCC_W'(1)))
    else $error("miss with free frame did not grow occupancy");

endmodule
